FILE: rtl/pctd_pkg.sv
// Package for the trial-division prime counter.
// Holds default sizes and the control and status groups shared by the modules.
// No dependencies.
package pctd_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;
    localparam int PRIME_COUNT_W  = 16;

    typedef struct packed {
        logic start;
        logic ack;
    } pctd_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic prime;
    } pctd_status_t;

endpackage

FILE: rtl/pctd_if.sv
// Channel interfaces of the prime counter: the input item and the result item.
// Depends on pctd_pkg for default widths.
interface pctd_req_if #(
    parameter int VALUE_BITS = pctd_pkg::VALUE_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;

    modport source (output valid, value, last, input ready);
    modport sink (input valid, value, last, output ready);
endinterface

interface pctd_rsp_if ();
    logic                                  valid;
    logic                                  ready;
    logic                                  is_prime;
    logic [pctd_pkg::PRIME_COUNT_W-1:0]    prime_count;
    logic                                  all_prime;
    logic                                  end_of_array;

    modport source (output valid, is_prime, prime_count, all_prime, end_of_array,
                    input ready);
    modport sink (input valid, is_prime, prime_count, all_prime, end_of_array,
                  output ready);
endinterface

FILE: rtl/pctd_divider.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on nothing beyond its parameter.
module pctd_divider #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic                  rem_zero
);
    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    assign trial = {rem_reg, shift_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            shift_next = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[VALUE_BITS-1:0];
            end
            else
            begin
                rem_next = trial[VALUE_BITS-1:0];
            end
            shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);
endmodule

FILE: rtl/pctd_tester.sv
// Primality sequencer: steps divisors from two while the divisor squared is at
// most the value. Depends on pctd_pkg and pctd_divider.
module pctd_tester #(
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pctd_pkg::pctd_ctrl_t        ctrl,
    input  logic [VALUE_BITS-1:0]       value,
    output pctd_pkg::pctd_status_t      status
);
    import pctd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic                  prime_reg, prime_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [VALUE_BITS-1:0] sq_reg, sq_next;
    logic                  div_start;
    logic                  div_done;
    logic                  div_rem_zero;

    pctd_divider #(.VALUE_BITS(VALUE_BITS)) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .rem_zero (div_rem_zero)
    );

    always_comb
    begin
        state_next = state_reg;
        prime_next = prime_reg;
        v_next     = v_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    v_next  = value;
                    d_next  = VALUE_BITS'(2);
                    sq_next = VALUE_BITS'(4);
                    if (value[VALUE_BITS-1] || (value < VALUE_BITS'(2)))
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > v_reg)
                begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next     = d_reg + VALUE_BITS'(1);
                        sq_next    = sq_reg + {d_reg[VALUE_BITS-2:0], 1'b1};
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        v_reg     <= v_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
    end

    assign status.idle  = (state_reg == ST_IDLE);
    assign status.done  = (state_reg == ST_DONE);
    assign status.prime = prime_reg;
endmodule

FILE: rtl/prime_count_trial_division.sv
// Top level of the trial-division prime counter: handshakes, tallies, result register.
// Depends on pctd_pkg, pctd_if and pctd_tester.
//
// Each item is tested by trying divisors from two upward while the divisor squared
// stays at or below the value, each divisor passing through the bit-serial
// remainder unit. Values below two and negatives are rejected, and two and three
// are found prime, without any division; even values stop after the first divisor.
// One item is tested at a time; a new item is taken while the previous result still
// waits in the output register. The prime count saturates at 2^COUNT_BITS - 1, and
// both the count and the all-prime flag restart after the item marked last.
module prime_count_trial_division #(
    parameter int VALUE_BITS = pctd_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = pctd_pkg::COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pctd_req_if.sink   req,
    pctd_rsp_if.source rsp
);
    import pctd_pkg::*;

    pctd_ctrl_t      ctrl;
    pctd_status_t    status;
    logic            load;
    logic            inc;
    logic [COUNT_BITS-1:0] cnt_new;
    logic            allp_new;

    logic                     last_reg, last_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic                     allp_reg, allp_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_prime_reg;
    logic [PRIME_COUNT_W-1:0] out_count_reg;
    logic                     out_allp_reg;
    logic                     out_last_reg;

    pctd_tester #(.VALUE_BITS(VALUE_BITS)) u_tester (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .value  (req.value),
        .status (status)
    );

    assign req.ready  = status.idle;
    assign load       = status.done && (!out_valid_reg || rsp.ready);
    assign ctrl.start = req.valid && status.idle;
    assign ctrl.ack   = load;

    assign inc      = status.prime && (count_reg != {COUNT_BITS{1'b1}});
    assign cnt_new  = count_reg + COUNT_BITS'(inc);
    assign allp_new = allp_reg & status.prime;

    always_comb
    begin
        last_next      = last_reg;
        count_next     = count_reg;
        allp_next      = allp_reg;
        out_valid_next = out_valid_reg;
        if (ctrl.start)
        begin
            last_next = req.last;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            if (last_reg)
            begin
                count_next = '0;
                allp_next  = 1'b1;
            end
            else
            begin
                count_next = cnt_new;
                allp_next  = allp_new;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            allp_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            allp_reg      <= allp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        if (load)
        begin
            out_prime_reg <= status.prime;
            out_count_reg <= PRIME_COUNT_W'(cnt_new);
            out_allp_reg  <= allp_new;
            out_last_reg  <= last_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.is_prime     = out_prime_reg;
    assign rsp.prime_count  = out_count_reg;
    assign rsp.all_prime    = out_allp_reg;
    assign rsp.end_of_array = out_last_reg;
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the trial-division prime counter.
// Depends on pctd_pkg, the pctd_req_if and pctd_rsp_if interfaces, and the top level.
// Directed, random and back-pressure tests are checked against a local predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pctd_pkg::*;

    localparam int VALUE_BITS     = VALUE_BITS_DEF;
    localparam int COUNT_BITS     = COUNT_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_REPORTS    = 40;
    localparam int PRIME_SET_N    = 10;
    localparam int PRIME_SET[PRIME_SET_N] = '{2, 3, 5, 7, 11, 13, 101, 509, 997, 7919};
    localparam logic [PRIME_COUNT_W-1:0] COUNT_MAX = PRIME_COUNT_W'((1 << COUNT_BITS) - 1);

    typedef struct packed {
        logic                     is_prime;
        logic [PRIME_COUNT_W-1:0] prime_count;
        logic                     all_prime;
        logic                     end_of_array;
    } tally_result_t;

    logic clk;
    logic rst_n;

    pctd_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
    pctd_rsp_if rsp_ch ();

    prime_count_trial_division #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    tally_result_t            expected_results[$];
    logic [PRIME_COUNT_W-1:0] tally_count;
    logic                     tally_all_prime;
    int                       send_idle_pct;
    int                       recv_stall_pct;
    int                       hold_requests;
    int                       holds_taken;
    int                       hold_left;
    int                       error_count;
    int                       items_sent;
    int                       results_checked;
    int                       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.value <= '0;
        req_ch.last  <= 1'b0;
    end

    function automatic logic value_is_prime(logic signed [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] u;
        logic [VALUE_BITS-1:0] d;
        if (v < 2)
            return 1'b0;
        u = v;
        for (d = 2; d <= u / d; d++)
        begin
            if (u % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_tally(input logic signed [VALUE_BITS-1:0] v, input logic l);
        tally_result_t r;
        r.is_prime = value_is_prime(v);
        if (r.is_prime)
        begin
            if (tally_count < COUNT_MAX)
                tally_count = tally_count + 1'b1;
        end
        else
            tally_all_prime = 1'b0;
        r.prime_count  = tally_count;
        r.all_prime    = tally_all_prime;
        r.end_of_array = l;
        expected_results.push_back(r);
        if (l)
        begin
            tally_count     = '0;
            tally_all_prime = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < MAX_REPORTS)
            $display("tb: mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic signed [VALUE_BITS-1:0] v, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.value <= v;
        req_ch.last  <= l;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        predict_tally(v, l);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_for_results();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] random_value(bit prime_only);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (prime_only || sel < 15)
            return PRIME_SET[$urandom_range(0, PRIME_SET_N - 1)];
        if (sel < 50)
            return $urandom_range(0, 1000);
        if (sel < 60)
            return $urandom_range(0, 3);
        if (sel < 72)
            return 3 * $urandom_range(0, 715827882);
        if (sel < 82)
            return $urandom & 32'h7FFF_FFFE;
        if (sel < 90)
            return -$signed($urandom_range(1, 1000));
        return $urandom | 32'h8000_0000;
    endfunction

    task automatic send_random_arrays(input int n_items);
        int  sent;
        int  len;
        bit  prime_only;
        sent = 0;
        while (sent < n_items)
        begin
            len        = $urandom_range(1, 6);
            prime_only = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                send_item(random_value(prime_only), i == len - 1);
            sent += len;
        end
    endtask

    task automatic test_directed();
        int vals[22] = '{2, 3, 5, 7,
                         0, 1, -1,
                         32'sh8000_0000, -2147483647, 2147483646, 2147483645,
                         4, 9, 25, 1042441,
                         11, 9, 13,
                         65521, 1048573, 1048575,
                         2};
        bit ends[22] = '{0, 0, 0, 1,
                         0, 0, 1,
                         0, 0, 0, 1,
                         0, 0, 0, 1,
                         0, 0, 1,
                         0, 0, 1,
                         1};
        set_idling(0, 0);
        for (int i = 0; i < 22; i++)
            send_item(vals[i], ends[i]);
        req_ch.valid <= 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_idling();
        set_idling(0, 0);
        send_random_arrays(17);
        set_idling(88, 0);
        send_random_arrays(17);
        set_idling(0, 88);
        send_random_arrays(17);
        set_idling(34, 34);
        send_random_arrays(17);
        req_ch.valid <= 1'b0;
        wait_for_results();
    endtask

    task automatic test_back_pressure();
        set_idling(0, 0);
        hold_requests++;
        wait (holds_taken == hold_requests);
        for (int i = 0; i < 8; i++)
            send_item(random_value(i % 2 == 0), i == 7);
        req_ch.valid <= 1'b0;
        wait_for_results();
    endtask

    initial
    begin
        hold_left = 0;
        holds_taken = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (holds_taken != hold_requests)
            begin
                holds_taken++;
                hold_left = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        tally_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
                report_mismatch("result with no item pending", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.is_prime !== want.is_prime)
                    report_mismatch("is_prime", rsp_ch.is_prime, want.is_prime);
                if (rsp_ch.prime_count !== want.prime_count)
                    report_mismatch("prime_count", rsp_ch.prime_count, want.prime_count);
                if (rsp_ch.all_prime !== want.all_prime)
                    report_mismatch("all_prime", rsp_ch.all_prime, want.all_prime);
                if (rsp_ch.end_of_array !== want.end_of_array)
                    report_mismatch("end_of_array", rsp_ch.end_of_array, want.end_of_array);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: watchdog expired with %0d results pending", expected_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        tally_count     = '0;
        tally_all_prime = 1'b1;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_requests   = 0;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        quiet_cycles    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_idling();
        test_back_pressure();

        $display("tb: ran directed edge values, random arrays under four idling mixes,");
        $display("tb: and a long receiver hold; %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_checked, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pctd_pkg.sv
rtl/pctd_if.sv
rtl/pctd_divider.sv
rtl/pctd_tester.sv
rtl/prime_count_trial_division.sv
tb/sv/tb_top.sv
